// File: rtl/e2q_pkg.sv
// Shared types, fixed-point constants and rounding helpers for the Euler-to-quaternion block.
`timescale 1ns / 1ps

package e2q_pkg;

    // Field widths of the angle and quaternion beats.
    localparam int ANGLE_W    = 16;
    localparam int QUAT_W     = 16;

    // Internal fixed point: signed Q.30.
    localparam int IFRAC      = 30;
    // Half angle in Q.30 is the raw angle scaled by this shift.
    localparam int HALF_SHIFT = IFRAC + 3 - ANGLE_W;
    // Angle accumulator width: the half angle spans [-4, 4).
    localparam int ZW         = IFRAC + 3;
    // CORDIC x/y datapath width, with headroom over +/-1.0.
    localparam int XYW        = IFRAC + 4;
    // Width of sine, cosine and the partial quaternion components.
    localparam int CSW        = IFRAC + 2;
    // Full product width.
    localparam int PW         = 2 * CSW;
    // Width of a sum of two rounded products.
    localparam int RW         = CSW + 1;
    // Deepest CORDIC the arctangent table supports.
    localparam int CORDIC_MAX = 30;

    localparam logic signed [ZW-1:0]  PI_Q30      = 33'sd3373259426;
    localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [XYW-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q30 [0:CORDIC_MAX-1] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128,
        33'sd64,        33'sd32,        33'sd16,        33'sd8,
        33'sd4,         33'sd2
    };

    // Output scaling: Q.30 down to QUAT_W-2 fraction bits, rounded half up.
    localparam int OUT_SHIFT = IFRAC - (QUAT_W - 2);
    localparam logic signed [RW:0] OUT_RND = ((RW+1)'(1) <<< OUT_SHIFT) >>> 1;
    localparam logic signed [RW:0] ONE_EXT = (RW+1)'(1) <<< (QUAT_W - 2);
    localparam logic signed [QUAT_W-1:0] QONE = QUAT_W'(1) <<< (QUAT_W - 2);

    // Product rounding half up to Q.30.
    localparam logic signed [PW-1:0] PROD_RND = PW'(1) <<< (IFRAC - 1);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_s;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } quat_t;

    // Q.30 product rounded half up back to Q.30.
    function automatic logic signed [CSW-1:0] qround(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sum;
        sum = p + PROD_RND;
        return sum[IFRAC+CSW-1:IFRAC];
    endfunction

    // Round a Q.30 component to the output format and clamp to +/-1.0.
    function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [RW-1:0] r);
        logic signed [RW:0]       t;
        logic signed [QUAT_W-1:0] res;
        t = ((RW+1)'(r) + OUT_RND) >>> OUT_SHIFT;
        if (t > ONE_EXT)
            res = QONE;
        else if (t < -ONE_EXT)
            res = -QONE;
        else
            res = t[QUAT_W-1:0];
        return res;
    endfunction

endpackage

// File: rtl/e2q_ctrl.sv
// Pipeline valid bits and per-stage load enables with bubble collapsing.
`timescale 1ns / 1ps

module e2q_ctrl #(
    parameter int STAGES = 23
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_stall,
    output logic [STAGES-1:0] stage_en,
    output logic [STAGES-1:0] stage_valid
);
    import e2q_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // A stage may load when the output drains or some stage at or after it is empty.
    for (genvar k = 0; k < STAGES; k++) begin : g_en
        assign stage_en[k] = !out_stall || !(&valid_reg[STAGES-1:k]);
    end

    // Valid bits shift one stage along with the data.
    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (stage_en[k])
                    valid_reg[k] <= valid_next[k];
            end
        end
    end

    assign in_stall    = !stage_en[0];
    assign stage_valid = valid_reg;

endmodule

// File: rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half an input angle.
`timescale 1ns / 1ps

module e2q_cordic #(
    parameter int STEPS = 16
) (
    input  logic                               clk,
    input  logic [STEPS+1:0]                   en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
    output logic signed [e2q_pkg::CSW-1:0]     sine,
    output logic signed [e2q_pkg::CSW-1:0]     cosine
);
    import e2q_pkg::*;

    logic signed [XYW-1:0] x_reg [0:STEPS];
    logic signed [XYW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0]  z_reg [0:STEPS];
    logic                  neg_reg [0:STEPS];

    logic signed [ZW-1:0]  half_ang;
    logic signed [ZW-1:0]  z_next;
    logic                  neg_next;
    logic signed [CSW-1:0] sine_reg, sine_next;
    logic signed [CSW-1:0] cosine_reg, cosine_next;

    // Half angle in Q.30, folded into [-pi/2, pi/2]; the fold flips both outputs.
    always_comb
    begin
        half_ang = ZW'(angle) <<< HALF_SHIFT;
        z_next   = half_ang;
        neg_next = 1'b0;
        if (half_ang > HALF_PI_Q30)
        begin
            z_next   = half_ang - PI_Q30;
            neg_next = 1'b1;
        end
        else if (half_ang < -HALF_PI_Q30)
        begin
            z_next   = half_ang + PI_Q30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    // One micro-rotation per stage.
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic signed [XYW-1:0] dx, dy;
        logic signed [XYW-1:0] x_next, y_next;
        logic signed [ZW-1:0]  zs_next;

        assign dx = y_reg[k-1] >>> (k - 1);
        assign dy = x_reg[k-1] >>> (k - 1);

        always_comb
        begin
            if (z_reg[k-1] >= 0)
            begin
                x_next  = x_reg[k-1] - dx;
                y_next  = y_reg[k-1] + dy;
                zs_next = z_reg[k-1] - ATAN_Q30[k-1];
            end
            else
            begin
                x_next  = x_reg[k-1] + dx;
                y_next  = y_reg[k-1] - dy;
                zs_next = z_reg[k-1] + ATAN_Q30[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                z_reg[k]   <= zs_next;
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Undo the fold and trim to the product operand width.
    always_comb
    begin
        if (neg_reg[STEPS])
        begin
            sine_next   = CSW'(-y_reg[STEPS]);
            cosine_next = CSW'(-x_reg[STEPS]);
        end
        else
        begin
            sine_next   = CSW'(y_reg[STEPS]);
            cosine_next = CSW'(x_reg[STEPS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STEPS+1])
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

// File: rtl/e2q_hamilton.sv
// Pipelined Hamilton products Qz*Qy*Qx with rounding and output saturation.
`timescale 1ns / 1ps

module e2q_hamilton (
    input  logic                           clk,
    input  logic [4:0]                     en,
    input  logic signed [e2q_pkg::CSW-1:0] cx,
    input  logic signed [e2q_pkg::CSW-1:0] sx,
    input  logic signed [e2q_pkg::CSW-1:0] cy,
    input  logic signed [e2q_pkg::CSW-1:0] sy,
    input  logic signed [e2q_pkg::CSW-1:0] cz,
    input  logic signed [e2q_pkg::CSW-1:0] sz,
    output e2q_pkg::quat_t                 quat
);
    import e2q_pkg::*;

    // Stage 1: products of Qz*Qy (the zero terms of each factor drop out exactly).
    logic signed [PW-1:0]  p_czcy_reg, p_szsy_reg, p_czsy_reg, p_szcy_reg;
    logic signed [CSW-1:0] cx1_reg, sx1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_czcy_reg <= PW'(cz) * PW'(cy);
            p_szsy_reg <= PW'(sz) * PW'(sy);
            p_czsy_reg <= PW'(cz) * PW'(sy);
            p_szcy_reg <= PW'(sz) * PW'(cy);
            cx1_reg    <= cx;
            sx1_reg    <= sx;
        end
    end

    // Stage 2: round to Q.30, giving the partial quaternion m = Qz*Qy.
    logic signed [CSW-1:0] ms_reg, mx_reg, my_reg, mz_reg;
    logic signed [CSW-1:0] cx2_reg, sx2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ms_reg  <= qround(p_czcy_reg);
            mx_reg  <= -qround(p_szsy_reg);
            my_reg  <= qround(p_czsy_reg);
            mz_reg  <= qround(p_szcy_reg);
            cx2_reg <= cx1_reg;
            sx2_reg <= sx1_reg;
        end
    end

    // Stage 3: the eight nonzero products of m*Qx.
    logic signed [PW-1:0] p_mscx_reg, p_mxsx_reg, p_mssx_reg, p_mxcx_reg;
    logic signed [PW-1:0] p_mycx_reg, p_mzsx_reg, p_mzcx_reg, p_mysx_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_mscx_reg <= PW'(ms_reg) * PW'(cx2_reg);
            p_mxsx_reg <= PW'(mx_reg) * PW'(sx2_reg);
            p_mssx_reg <= PW'(ms_reg) * PW'(sx2_reg);
            p_mxcx_reg <= PW'(mx_reg) * PW'(cx2_reg);
            p_mycx_reg <= PW'(my_reg) * PW'(cx2_reg);
            p_mzsx_reg <= PW'(mz_reg) * PW'(sx2_reg);
            p_mzcx_reg <= PW'(mz_reg) * PW'(cx2_reg);
            p_mysx_reg <= PW'(my_reg) * PW'(sx2_reg);
        end
    end

    // Stage 4: round each product and combine into the four components.
    logic signed [RW-1:0] rs_reg, rx_reg, ry_reg, rz_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rs_reg <= RW'(qround(p_mscx_reg)) - RW'(qround(p_mxsx_reg));
            rx_reg <= RW'(qround(p_mssx_reg)) + RW'(qround(p_mxcx_reg));
            ry_reg <= RW'(qround(p_mycx_reg)) + RW'(qround(p_mzsx_reg));
            rz_reg <= RW'(qround(p_mzcx_reg)) - RW'(qround(p_mysx_reg));
        end
    end

    // Stage 5: output rounding and clamp; this is the output register.
    quat_t quat_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            quat_reg.quat_s <= to_out(rs_reg);
            quat_reg.quat_x <= to_out(rx_reg);
            quat_reg.quat_y <= to_out(ry_reg);
            quat_reg.quat_z <= to_out(rz_reg);
        end
    end

    assign quat = quat_reg;

endmodule

// File: rtl/euler_to_quaternion.sv
// Euler angles (Z-Y-X order) to orientation quaternion: top level.
// The pipeline holds one register stage per CORDIC micro-rotation, besides the range
//   reduction, sign fix and Hamilton product stages.
// Throughput: one beat per cycle; a bubble in the pipeline is filled even while the
//   output is stalled, and the input stalls only when every stage holds a beat.
// Reset clears only the stage valid bits; the datapath registers are not reset.
`timescale 1ns / 1ps

module euler_to_quaternion #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             angle_valid,
    output logic             angle_stall,
    input  e2q_pkg::angles_t angles,
    output logic             quat_valid,
    input  logic             quat_stall,
    output e2q_pkg::quat_t   quat
);
    import e2q_pkg::*;

    // Range reduction, the micro-rotations, sign fix, then five product stages.
    localparam int STAGES = CORDIC_STEPS + 7;
    localparam int HB     = CORDIC_STEPS + 2;

    logic [STAGES-1:0] stage_en;
    logic [STAGES-1:0] stage_valid;

    logic signed [CSW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

    e2q_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (angle_valid),
        .in_stall    (angle_stall),
        .out_stall   (quat_stall),
        .stage_en    (stage_en),
        .stage_valid (stage_valid)
    );

    e2q_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_x (
        .clk    (clk),
        .en     (stage_en[HB-1:0]),
        .angle  (angles.roll_angle),
        .sine   (sin_x),
        .cosine (cos_x)
    );

    e2q_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_y (
        .clk    (clk),
        .en     (stage_en[HB-1:0]),
        .angle  (angles.pitch_angle),
        .sine   (sin_y),
        .cosine (cos_y)
    );

    e2q_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_z (
        .clk    (clk),
        .en     (stage_en[HB-1:0]),
        .angle  (angles.yaw_angle),
        .sine   (sin_z),
        .cosine (cos_z)
    );

    e2q_hamilton u_hamilton (
        .clk  (clk),
        .en   (stage_en[STAGES-1:HB]),
        .cx   (cos_x),
        .sx   (sin_x),
        .cy   (cos_y),
        .sy   (sin_y),
        .cz   (cos_z),
        .sz   (sin_z),
        .quat (quat)
    );

    assign quat_valid = stage_valid[STAGES-1];

    // The pipeline always has room for a new beat when the output is draining.
    a_no_stall_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        !quat_stall |-> !angle_stall)
        else $error("input stalled while the output was draining");

    // With no output stall every valid bit moves one stage per cycle.
    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && !$past(quat_stall)) |->
        (stage_valid == {$past(stage_valid[STAGES-2:0]), $past(angle_valid)}))
        else $error("valid bits did not advance with a free output");

    // Every delivered component lies within plus or minus one.
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |->
        (quat.quat_s <= QONE) && (quat.quat_s >= -QONE) &&
        (quat.quat_x <= QONE) && (quat.quat_x >= -QONE) &&
        (quat.quat_y <= QONE) && (quat.quat_y >= -QONE) &&
        (quat.quat_z <= QONE) && (quat.quat_z >= -QONE))
        else $error("quaternion component outside the saturation range");

endmodule
